FILE: hdl/aesp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesp_pkg
// Shared types and constants of the terminal escape sequence parser.
// ----------------------------------------------------------------------------
package aesp_pkg;

    // controller states, one-hot
    typedef enum logic [5:0] {
        ST_GROUND  = 6'b000001,
        ST_ESC     = 6'b000010,
        ST_CSI     = 6'b000100,
        ST_STR     = 6'b001000,
        ST_STR_ESC = 6'b010000,
        ST_EMIT    = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        KIND_PRINT    = 2'd0,
        KIND_CONTROL  = 2'd1,
        KIND_ESC_DISP = 2'd2,
        KIND_CSI_PARM = 2'd3
    } t_event_kind;

    // configuration register indexes
    localparam logic CFG_SEQ_LIMIT = 1'b0;
    localparam logic CFG_STR_LIMIT = 1'b1;

    localparam logic [7:0]  SEQ_LIMIT_RST = 8'd64;
    localparam logic [15:0] STR_LIMIT_RST = 16'd4096;
    localparam logic [15:0] PARAM_MAX     = 16'hffff;
    localparam logic [16:0] LEN_MAX       = 17'h1ffff;

    // byte codes
    localparam logic [7:0] B_BEL    = 8'h07;
    localparam logic [7:0] B_ESC    = 8'h1b;
    localparam logic [7:0] B_DEL    = 8'h7f;
    localparam logic [7:0] B_LBR    = 8'h5b; // '['
    localparam logic [7:0] B_BSLASH = 8'h5c; // '\'

    // datapath status, one snapshot of the current byte and counters
    typedef struct packed {
        logic is_esc;
        logic is_c0;       // below 0x20 or DEL
        logic is_lbr;
        logic is_str_open; // ] P ^ _ X
        logic is_inter;    // 0x20-0x2f
        logic is_digit;
        logic is_sep;      // ; or :
        logic is_priv;     // ? < = >
        logic is_final;    // 0x40-0x7e
        logic is_bel;
        logic is_bslash;
        logic inter_flag;
        logic over_flag;
        logic over_seq;    // bumped length exceeds sequence limit
        logic over_str;    // bumped length exceeds string limit
        logic len_one;     // bumped length is one
        logic sep_room;
        logic emit_last;
        logic out_free;
    } t_stat;

    // controller commands
    typedef struct packed {
        logic        clr_len;
        logic        clr_inter;
        logic        clr_csi;     // count, private, overlong, accumulator
        logic        bump;
        logic        set_inter;
        logic        set_priv;
        logic        set_over;
        logic        digit;
        logic        sep;
        logic        store_final;
        logic        start_emit;
        logic        emit_step;
        logic        load_single;
        t_event_kind kind;
    } t_cmd;

endpackage

FILE: hdl/aesp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesp_ctrl
// Parser state machine: decides per accepted byte which datapath actions run,
// and steps the parameter run out of the store.
// ----------------------------------------------------------------------------
module aesp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  aesp_pkg::t_stat i_stat,
    output aesp_pkg::t_cmd  o_cmd
);

    aesp_pkg::t_state r_state, n_state;
    logic             w_acc;

    assign o_in_stall = (r_state == aesp_pkg::ST_EMIT) || !i_stat.out_free;
    assign w_acc      = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.kind = aesp_pkg::KIND_PRINT;
        unique case (r_state)
            aesp_pkg::ST_GROUND: begin
                if (w_acc) begin
                    o_cmd.load_single = 1'b1;
                    if (i_stat.is_c0) begin
                        o_cmd.kind = aesp_pkg::KIND_CONTROL;
                        if (i_stat.is_esc) begin
                            o_cmd.clr_len   = 1'b1;
                            o_cmd.clr_inter = 1'b1;
                            n_state = aesp_pkg::ST_ESC;
                        end
                    end
                end
            end
            aesp_pkg::ST_ESC: begin
                if (w_acc && !i_stat.is_esc) begin
                    if (i_stat.is_lbr) begin
                        o_cmd.clr_len   = 1'b1;
                        o_cmd.clr_inter = 1'b1;
                        o_cmd.clr_csi   = 1'b1;
                        n_state = aesp_pkg::ST_CSI;
                    end else if (i_stat.is_str_open) begin
                        o_cmd.clr_len = 1'b1;
                        n_state = aesp_pkg::ST_STR;
                    end else if (i_stat.is_inter) begin
                        o_cmd.set_inter = 1'b1;
                        o_cmd.bump      = 1'b1;
                        if (i_stat.over_seq) n_state = aesp_pkg::ST_GROUND;
                    end else begin
                        n_state = aesp_pkg::ST_GROUND;
                        if (!i_stat.inter_flag) begin
                            o_cmd.load_single = 1'b1;
                            o_cmd.kind        = aesp_pkg::KIND_ESC_DISP;
                        end
                    end
                end
            end
            aesp_pkg::ST_CSI: begin
                if (w_acc) begin
                    if (i_stat.is_esc) begin
                        o_cmd.clr_len   = 1'b1;
                        o_cmd.clr_inter = 1'b1;
                        n_state = aesp_pkg::ST_ESC;
                    end else begin
                        o_cmd.bump = 1'b1;
                        if (i_stat.over_seq) o_cmd.set_over = 1'b1;
                        if (i_stat.is_digit) begin
                            o_cmd.digit = !i_stat.inter_flag;
                        end else if (i_stat.is_sep) begin
                            o_cmd.sep = i_stat.sep_room;
                        end else if (i_stat.is_priv && i_stat.len_one) begin
                            o_cmd.set_priv = 1'b1;
                        end else if (i_stat.is_inter) begin
                            o_cmd.set_inter = 1'b1;
                        end else if (i_stat.is_final) begin
                            if (!i_stat.over_flag && !i_stat.over_seq &&
                                !i_stat.inter_flag) begin
                                o_cmd.store_final = 1'b1;
                                o_cmd.start_emit  = 1'b1;
                                n_state = aesp_pkg::ST_EMIT;
                            end else begin
                                n_state = aesp_pkg::ST_GROUND;
                            end
                        end else begin
                            // stray byte spoils the sequence
                            o_cmd.set_over = 1'b1;
                        end
                    end
                end
            end
            aesp_pkg::ST_STR: begin
                if (w_acc) begin
                    if (i_stat.is_bel) begin
                        n_state = aesp_pkg::ST_GROUND;
                    end else if (i_stat.is_esc) begin
                        n_state = aesp_pkg::ST_STR_ESC;
                    end else begin
                        o_cmd.bump = 1'b1;
                        if (i_stat.over_str) n_state = aesp_pkg::ST_GROUND;
                    end
                end
            end
            aesp_pkg::ST_STR_ESC: begin
                if (w_acc) begin
                    if (i_stat.is_bslash)    n_state = aesp_pkg::ST_GROUND;
                    else if (!i_stat.is_esc) n_state = aesp_pkg::ST_STR;
                end
            end
            aesp_pkg::ST_EMIT: begin
                o_cmd.kind = aesp_pkg::KIND_CSI_PARM;
                if (i_stat.out_free) begin
                    o_cmd.emit_step = 1'b1;
                    if (i_stat.emit_last) n_state = aesp_pkg::ST_GROUND;
                end
            end
            default: n_state = aesp_pkg::ST_GROUND;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aesp_pkg::ST_GROUND;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hdl/aesp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesp_dp
// Parser datapath: byte decode, length counter, flags, parameter accumulator,
// parameter store, limit registers and the output register.
// ----------------------------------------------------------------------------
module aesp_dp #(
    parameter int PARAM_SLOTS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_data_byte,
    input  logic           i_cfg_we,
    input  logic           i_cfg_index,
    input  logic [15:0]    i_cfg_data,
    input  aesp_pkg::t_cmd i_cmd,
    output aesp_pkg::t_stat o_stat,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [1:0]     o_event_kind,
    output logic [7:0]     o_event_byte,
    output logic           o_private_marker,
    output logic [3:0]     o_param_index,
    output logic [15:0]    o_param_value,
    output logic           o_last_of_run
);

    localparam int SLOT_CAP = (PARAM_SLOTS < 16) ? PARAM_SLOTS : 16;
    localparam int IDX_W    = (SLOT_CAP > 1) ? $clog2(SLOT_CAP) : 1;

    logic [7:0]  r_seq_limit;
    logic [15:0] r_str_limit;
    logic [16:0] r_len;
    logic [16:0] w_len_inc;
    logic [3:0]  r_count;
    logic [3:0]  r_eidx;
    logic        r_inter, r_priv, r_over;
    logic [15:0] r_cur;
    logic [19:0] w_prod;
    logic [15:0] w_cur_next;
    logic [7:0]  r_final;
    logic [15:0] r_store [SLOT_CAP];
    logic        r_out_valid;
    logic        w_out_free;
    logic [7:0]  b;

    assign b = i_data_byte;

    // saturating length after this byte
    assign w_len_inc = (r_len == aesp_pkg::LEN_MAX) ? r_len : r_len + 17'd1;

    // cur * 10 + digit, saturated
    assign w_prod     = {1'b0, r_cur, 3'b000} + {3'b000, r_cur, 1'b0} + {16'd0, b[3:0]};
    assign w_cur_next = (w_prod > {4'd0, aesp_pkg::PARAM_MAX}) ? aesp_pkg::PARAM_MAX
                                                                : w_prod[15:0];

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_stat             = '0;
        o_stat.is_esc      = (b == aesp_pkg::B_ESC);
        o_stat.is_c0       = (b < 8'h20) || (b == aesp_pkg::B_DEL);
        o_stat.is_lbr      = (b == aesp_pkg::B_LBR);
        o_stat.is_str_open = (b == 8'h5d) || (b == 8'h50) || (b == 8'h5e) ||
                             (b == 8'h5f) || (b == 8'h58);
        o_stat.is_inter    = (b >= 8'h20) && (b <= 8'h2f);
        o_stat.is_digit    = (b >= 8'h30) && (b <= 8'h39);
        o_stat.is_sep      = (b == 8'h3b) || (b == 8'h3a);
        o_stat.is_priv     = (b >= 8'h3c) && (b <= 8'h3f);
        o_stat.is_final    = (b >= 8'h40) && (b <= 8'h7e);
        o_stat.is_bel      = (b == aesp_pkg::B_BEL);
        o_stat.is_bslash   = (b == aesp_pkg::B_BSLASH);
        o_stat.inter_flag  = r_inter;
        o_stat.over_flag   = r_over;
        o_stat.over_seq    = w_len_inc > {9'd0, r_seq_limit};
        o_stat.over_str    = w_len_inc > {1'b0, r_str_limit};
        o_stat.len_one     = (w_len_inc == 17'd1);
        o_stat.sep_room    = ({1'b0, r_count} + 5'd1) < 5'(SLOT_CAP);
        o_stat.emit_last   = (r_eidx == r_count);
        o_stat.out_free    = w_out_free;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_limit <= aesp_pkg::SEQ_LIMIT_RST;
            r_str_limit <= aesp_pkg::STR_LIMIT_RST;
            r_len       <= '0;
            r_count     <= '0;
            r_inter     <= 1'b0;
            r_priv      <= 1'b0;
            r_over      <= 1'b0;
            r_eidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    aesp_pkg::CFG_SEQ_LIMIT: r_seq_limit <= i_cfg_data[7:0];
                    aesp_pkg::CFG_STR_LIMIT: r_str_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clr_len)        r_len <= '0;
            else if (i_cmd.bump)      r_len <= w_len_inc;
            if (i_cmd.clr_inter)      r_inter <= 1'b0;
            else if (i_cmd.set_inter) r_inter <= 1'b1;
            if (i_cmd.clr_csi) begin
                r_count <= '0;
                r_priv  <= 1'b0;
                r_over  <= 1'b0;
            end else begin
                if (i_cmd.sep)      r_count <= r_count + 4'd1;
                if (i_cmd.set_priv) r_priv  <= 1'b1;
                if (i_cmd.set_over) r_over  <= 1'b1;
            end
            if (i_cmd.start_emit)     r_eidx <= '0;
            else if (i_cmd.emit_step) r_eidx <= r_eidx + 4'd1;
            if (i_cmd.load_single || i_cmd.emit_step) r_out_valid <= 1'b1;
            else if (!i_out_stall)                     r_out_valid <= 1'b0;
        end
    end

    // accumulator and final byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_csi || i_cmd.sep) r_cur <= '0;
        else if (i_cmd.digit)           r_cur <= w_cur_next;
        if (i_cmd.start_emit)           r_final <= b;
    end

    // parameter store: a slot is written when its parameter closes
    always_ff @(posedge i_clk) begin
        if (i_cmd.sep || i_cmd.store_final) begin
            r_store[r_count[IDX_W-1:0]] <= r_cur;
        end
    end

    // output register; the store read is registered here
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_step) begin
            o_event_kind     <= i_cmd.kind;
            o_event_byte     <= r_final;
            o_private_marker <= r_priv;
            o_param_index    <= r_eidx;
            o_param_value    <= r_store[r_eidx[IDX_W-1:0]];
            o_last_of_run    <= (r_eidx == r_count);
        end else if (i_cmd.load_single) begin
            o_event_kind     <= i_cmd.kind;
            o_event_byte     <= b;
            o_private_marker <= 1'b0;
            o_param_index    <= '0;
            o_param_value    <= '0;
            o_last_of_run    <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: hdl/ansi_escape_sequence_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_escape_sequence_parser
// Terminal byte stream parser: print, control, escape dispatch and control
// sequence parameter events.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one i_data_byte per request.
// Output channel: o_out_valid / i_out_stall carry one event per request,
// held stable while stalled.
// A print, control or escape dispatch event for a taken byte appears in the
// output register on the next cycle. A good control sequence final byte
// starts a parameter run: one event per stored parameter, one per cycle
// while the receiver does not stall, from the parameter store read port, and
// input stalls for the run. Sustained rate is one byte per cycle while the
// receiver does not stall, apart from parameter runs. Input also stalls
// while an event waits in the output register and the receiver stalls; the
// single output register is the only buffering. Reset returns the parser to
// ground and the limits to 64 and 4096. Configuration: i_cfg_we writes
// i_cfg_data to register i_cfg_index (0 sequence limit, 1 string limit).
// Write only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ansi_escape_sequence_parser #(
    parameter int PARAM_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_event_kind,
    output logic [7:0]  o_event_byte,
    output logic        o_private_marker,
    output logic [3:0]  o_param_index,
    output logic [15:0] o_param_value,
    output logic        o_last_of_run,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    aesp_pkg::t_cmd  w_cmd;
    aesp_pkg::t_stat w_stat;

    aesp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    aesp_dp #(
        .PARAM_SLOTS (PARAM_SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_data_byte      (i_data_byte),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_event_kind     (o_event_kind),
        .o_event_byte     (o_event_byte),
        .o_private_marker (o_private_marker),
        .o_param_index    (o_param_index),
        .o_param_value    (o_param_value),
        .o_last_of_run    (o_last_of_run)
    );

endmodule
